// File: design/llkc_pkg.sv
// ----------------------------------------------------------------------------
// llkc_pkg
// Shared types, constants and the keyword table of the log line classifier.
// ----------------------------------------------------------------------------
package llkc_pkg;

  localparam int WIN_DEPTH = 18;
  localparam int KW_MAX    = WIN_DEPTH + 1;
  localparam int KW_NUM    = 26;
  localparam int CAT_NUM   = 8;

  typedef logic [7:0]           byte_t;
  typedef logic [CAT_NUM-1:0]   cat_mask_t;
  typedef logic [KW_MAX*8-1:0]  kw_text_t;
  typedef logic [4:0]           kw_len_t;
  typedef logic [2:0]           kw_cat_t;
  typedef logic [KW_MAX-1:0][7:0] match_buf_t;

  typedef enum logic [2:0] {
    CAT_STARTUP    = 3'd0,
    CAT_FAILED     = 3'd1,
    CAT_WARN       = 3'd2,
    CAT_ERROR      = 3'd3,
    CAT_HARDWARE   = 3'd4,
    CAT_NETWORK    = 3'd5,
    CAT_AUTH       = 3'd6,
    CAT_FILESYSTEM = 3'd7
  } cat_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Text is right-justified: the last keyword byte sits in bits [7:0].
  localparam kw_text_t KW_TEXT [KW_NUM] = '{
    kw_text_t'("startup finished in"), kw_text_t'("reached target"),
    kw_text_t'("failed"),   kw_text_t'("warn"),     kw_text_t'("error"),
    kw_text_t'("critical"), kw_text_t'("usb"),      kw_text_t'("pci"),
    kw_text_t'("sda"),      kw_text_t'("nvme"),     kw_text_t'("driver"),
    kw_text_t'("firmware"), kw_text_t'("network"),  kw_text_t'("eth0"),
    kw_text_t'("wlan"),     kw_text_t'("dhcp"),     kw_text_t'("ip"),
    kw_text_t'("sudo"),     kw_text_t'("authentication"), kw_text_t'("passwd"),
    kw_text_t'("login"),    kw_text_t'("mount"),    kw_text_t'("fsck"),
    kw_text_t'("ext4"),     kw_text_t'("btrfs"),    kw_text_t'("ntfs")
  };

  localparam kw_len_t KW_LEN [KW_NUM] = '{
    5'd19, 5'd14, 5'd6, 5'd4, 5'd5, 5'd8, 5'd3, 5'd3, 5'd3, 5'd4, 5'd6,
    5'd8, 5'd7, 5'd4, 5'd4, 5'd4, 5'd2, 5'd4, 5'd14, 5'd6, 5'd5, 5'd5,
    5'd4, 5'd4, 5'd5, 5'd4
  };

  localparam cat_e KW_CAT [KW_NUM] = '{
    CAT_STARTUP, CAT_STARTUP, CAT_FAILED, CAT_WARN, CAT_ERROR, CAT_ERROR,
    CAT_HARDWARE, CAT_HARDWARE, CAT_HARDWARE, CAT_HARDWARE, CAT_HARDWARE,
    CAT_HARDWARE, CAT_NETWORK, CAT_NETWORK, CAT_NETWORK, CAT_NETWORK,
    CAT_NETWORK, CAT_AUTH, CAT_AUTH, CAT_AUTH, CAT_AUTH, CAT_FILESYSTEM,
    CAT_FILESYSTEM, CAT_FILESYSTEM, CAT_FILESYSTEM, CAT_FILESYSTEM
  };

  function automatic byte_t fold_case(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: design/llkc_cell.sv
// ----------------------------------------------------------------------------
// llkc_cell
// One byte of the line window; takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module llkc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  llkc_pkg::cell_ctl_t ctl,
  input  llkc_pkg::byte_t   d_in,
  output llkc_pkg::byte_t   q
);
  import llkc_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

// File: design/llkc_match.sv
// ----------------------------------------------------------------------------
// llkc_match
// Parallel compare of the current byte and window against the keyword table.
// ----------------------------------------------------------------------------
module llkc_match (
  input  llkc_pkg::match_buf_t buf_in,
  output llkc_pkg::cat_mask_t  hit
);
  import llkc_pkg::*;

  logic [KW_NUM-1:0] kw_hit;

  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      kw_hit[k] = 1'b1;
      for (int i = 0; i < KW_MAX; i++) begin
        if (5'(i) < KW_LEN[k] && buf_in[i] != KW_TEXT[k][i*8 +: 8]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (kw_hit[k]) begin
        hit[KW_CAT[k]] = 1'b1;
      end
    end
  end

endmodule

// File: design/log_line_keyword_classifier.sv
// ----------------------------------------------------------------------------
// log_line_keyword_classifier
// Streams log bytes and gives a keyword category mask at each line end.
// ----------------------------------------------------------------------------
// Input channel: one text byte per beat (in_text_byte) with in_line_end set
// on the last byte of a line. Bytes are matched case-insensitively against
// the keyword table; a zero byte ends the text of its line and later bytes
// of that line are ignored, though their line end still counts.
// Output channel: one category_mask beat per line, bit k for category k.
// Throughput: one byte per cycle while in_ready is high, set by the 18-cell
// window shift chain and the combinational keyword compare against it.
// The mask is registered and is on out_category_mask in the cycle after the
// line end beat is taken. The output register holds it while out_ready is
// low; a new byte is still taken as long as the register is empty or being
// drained, so a stalled receiver only holds the input back while a mask waits.
// Reset: window, running mask and zero flag clear; no output is pending.
// ----------------------------------------------------------------------------
module log_line_keyword_classifier (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  llkc_pkg::byte_t       in_text_byte,
  input  logic                  in_line_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output llkc_pkg::cat_mask_t   out_category_mask
);
  import llkc_pkg::*;

  logic       beat;
  logic       live;
  byte_t      folded;
  cell_ctl_t  ctl;
  match_buf_t buf_vec;
  cat_mask_t  hit;
  cat_mask_t  line_mask;

  cat_mask_t  running_mask_r, running_mask_nxt;
  logic       zero_seen_r, zero_seen_nxt;
  logic       out_valid_r, out_valid_nxt;
  cat_mask_t  out_mask_r, out_mask_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign beat     = in_valid && in_ready;
  assign folded   = fold_case(in_text_byte);
  assign live     = !zero_seen_r && (in_text_byte != '0);

  assign ctl.shift = beat && live;
  assign ctl.clear = beat && in_line_end;

  assign buf_vec[0] = folded;

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_win
    llkc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .d_in  (buf_vec[g]),
      .q     (buf_vec[g+1])
    );
  end

  llkc_match u_match (
    .buf_in (buf_vec),
    .hit    (hit)
  );

  assign line_mask = live ? (running_mask_r | hit) : running_mask_r;

  always_comb begin
    running_mask_nxt = running_mask_r;
    zero_seen_nxt    = zero_seen_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_mask_nxt     = out_mask_r;
    if (beat) begin
      if (in_line_end) begin
        running_mask_nxt = '0;
        zero_seen_nxt    = 1'b0;
        out_valid_nxt    = 1'b1;
        out_mask_nxt     = line_mask;
      end else begin
        running_mask_nxt = line_mask;
        zero_seen_nxt    = zero_seen_r || (in_text_byte == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_mask_r <= '0;
      zero_seen_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      running_mask_r <= running_mask_nxt;
      zero_seen_r    <= zero_seen_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_category_mask = out_mask_r;

`ifndef SYNTHESIS
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && in_line_end) |=> (running_mask_r == '0) && !zero_seen_r && out_valid_r)
    else $error("line state not cleared after line end beat");

  a_zero_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (zero_seen_r && !(beat && in_line_end)) |=> zero_seen_r)
    else $error("zero flag dropped inside a line");

  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    !(beat && in_line_end) |=>
      ((running_mask_r & $past(running_mask_r)) == $past(running_mask_r)))
    else $error("running mask lost a bit inside a line");

  a_zero_freezes_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (zero_seen_r && !(beat && in_line_end)) |=> $stable(running_mask_r))
    else $error("mask changed after zero byte");
`endif

endmodule
